// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL of the particle push block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/gbpp_pkg.sv -----
// Types, constants and the expm1 table of the Gaussian beam particle push.
package gbpp_pkg;

    localparam int WORD_W    = 32;
    localparam int DIV_W     = 64;
    localparam int CFG_IDX_W = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KICK_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_2SIGSQ = 2'd2;

    localparam logic [WORD_W-1:0] RST_TIME_STEP  = 32'd65536;
    localparam logic [WORD_W-1:0] RST_KICK_GAIN  = 32'd0;
    localparam logic [WORD_W-1:0] RST_INV_2SIGSQ = 32'd32768;

    // expm1 table geometry; the argument t is Q16.16 below 16.0
    localparam int EXP_TABLE_BITS = 8;
    localparam int TAB_N          = 1 << EXP_TABLE_BITS;
    localparam int T_W            = 20;
    localparam int FRAC_BITS      = T_W - EXP_TABLE_BITS;
    localparam int H_W            = 31;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    // small-argument reciprocal term, Q32, below 2^48
    localparam int M_SMALL_W = 48;

    // reciprocal pipeline
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = DIV_W / DIV_BITS_PER_STAGE;

    typedef logic [H_W-1:0] t_htab [0:TAB_N];

    typedef struct packed {
        logic signed [WORD_W-1:0] px;
        logic signed [WORD_W-1:0] py;
        logic signed [WORD_W-1:0] vx;
        logic signed [WORD_W-1:0] vy;
        logic                     sat;
        logic                     last;
    } t_pkt;

    typedef struct packed {
        t_pkt                 pkt;
        logic                 big;
        logic [M_SMALL_W-1:0] m_small;
    } t_div_payload;

    // shift-subtract quotient, used only while the table is elaborated
    function automatic logic [63:0] const_quot(input logic [63:0] num,
                                               input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // h(t) = -expm1(-t)/t in Q30, sampled at 16k/TAB_N
    function automatic t_htab build_htab();
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] e1;
        logic [63:0] ek;
        t_htab       tab;
        term = 64'd1 << 60;
        pos  = term;
        neg  = '0;
        for (int n = 1; n <= 40; n++) begin
            term = const_quot(term >> (EXP_TABLE_BITS - 4), 64'(n));
            if (n[0]) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        e1 = ((pos - neg) + (64'd1 << 29)) >> 30;
        tab[0] = H_W'(ONE_Q30);
        ek = ONE_Q30;
        for (int k = 1; k <= TAB_N; k++) begin
            ek = (ek * e1 + (64'd1 << 29)) >> 30;
            tab[k] = H_W'(const_quot((ONE_Q30 - ek) << EXP_TABLE_BITS,
                                     64'(k) * 64'd16));
        end
        return tab;
    endfunction

    localparam t_htab H_TAB = build_htab();

endpackage

// ----- rtl/core/gbpp_div.sv -----
// Pipelined reciprocal unit: floor((2^64 - 1) / divisor), payload carried alongside.
`include "assert_macros.svh"

module gbpp_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [gbpp_pkg::DIV_W-1:0]    i_divisor,
    input  gbpp_pkg::t_div_payload        i_payload,
    output logic                          o_valid,
    output logic [gbpp_pkg::DIV_W-1:0]    o_quotient,
    output gbpp_pkg::t_div_payload        o_payload
);
    import gbpp_pkg::*;

    logic [DIV_W-1:0] r_rem [DIV_STAGES];
    logic [DIV_W-1:0] r_q   [DIV_STAGES];
    logic [DIV_W-1:0] r_d   [DIV_STAGES];
    t_div_payload     r_pl  [DIV_STAGES];
    logic [DIV_STAGES-1:0] r_v;

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [DIV_W-1:0] rem_in;
        logic [DIV_W-1:0] q_in;
        logic [DIV_W-1:0] d_in;
        logic             v_in;
        t_div_payload     pl_in;
        logic [DIV_W-1:0] n_rem;
        logic [DIV_W-1:0] n_q;
        logic [DIV_W:0]   shifted;

        if (s == 0) begin : g_first
            assign rem_in = '0;
            assign q_in   = '0;
            assign d_in   = i_divisor;
            assign v_in   = i_valid;
            assign pl_in  = i_payload;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign q_in   = r_q[s-1];
            assign d_in   = r_d[s-1];
            assign v_in   = r_v[s-1];
            assign pl_in  = r_pl[s-1];
        end

        // retire quotient bits of this stage; dividend bits are all ones
        always_comb begin
            n_rem   = rem_in;
            n_q     = q_in;
            shifted = '0;
            for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
                shifted = {n_rem, 1'b1};
                if (shifted >= {1'b0, d_in}) begin
                    n_rem = DIV_W'(shifted - {1'b0, d_in});
                    n_q   = {n_q[DIV_W-2:0], 1'b1};
                end else begin
                    n_rem = shifted[DIV_W-1:0];
                    n_q   = {n_q[DIV_W-2:0], 1'b0};
                end
            end
        end

        // advance data
        always_ff @(posedge i_clk) begin
            r_rem[s] <= n_rem;
            r_q[s]   <= n_q;
            r_d[s]   <= d_in;
            r_pl[s]  <= pl_in;
        end

        // advance valid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else begin
                r_v[s] <= v_in;
            end
        end
    end

    assign o_valid    = r_v[DIV_STAGES-1];
    assign o_quotient = r_q[DIV_STAGES-1];
    assign o_payload  = r_pl[DIV_STAGES-1];

    `ASSERT_IMPLIES(a_rem_below_div, i_clk, i_rst_n, r_v[DIV_STAGES-1], (r_d[DIV_STAGES-1] == '0) || (r_rem[DIV_STAGES-1] < r_d[DIV_STAGES-1]))

endmodule

// ----- rtl/core/gaussian_beam_particle_push.sv -----
// Top level of the Gaussian beam particle push: drift, beam field kick, saturation.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------------
//  item    | in        | start & !busy       | i_pos_x/y, i_vel_x/y, i_last_particle
//  result  | out       | o_done (one cycle)  | o_new_pos_x/y, o_new_vel_x/y, o_saturated,
//          |           |                     | o_last_out
//  config  | in        | i_cfg_we            | i_cfg_idx, i_cfg_wdata
//
// One particle may enter every cycle while busy is low; o_done is driven by the last of
// 47 register stages, the first loaded at the accepting edge: 10 front stages, 32 stages
// of the 2-bit-per-stage reciprocal unit, 5 kick and output stages.
// Throughput is one particle per clock while busy is low.
// Reset restores the register defaults and clears all valid bits; busy is high during
// reset and for the first edge after it, and low otherwise.
// Results are pushed out without back-pressure.
`include "assert_macros.svh"

module gaussian_beam_particle_push (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [gbpp_pkg::WORD_W-1:0] i_pos_x,
    input  logic signed [gbpp_pkg::WORD_W-1:0] i_pos_y,
    input  logic signed [gbpp_pkg::WORD_W-1:0] i_vel_x,
    input  logic signed [gbpp_pkg::WORD_W-1:0] i_vel_y,
    input  logic                              i_last_particle,
    input  logic                              i_cfg_we,
    input  logic [gbpp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gbpp_pkg::WORD_W-1:0]       i_cfg_wdata,
    output logic                              o_done,
    output logic signed [gbpp_pkg::WORD_W-1:0] o_new_pos_x,
    output logic signed [gbpp_pkg::WORD_W-1:0] o_new_pos_y,
    output logic signed [gbpp_pkg::WORD_W-1:0] o_new_vel_x,
    output logic signed [gbpp_pkg::WORD_W-1:0] o_new_vel_y,
    output logic                              o_saturated,
    output logic                              o_last_out
);
    import gbpp_pkg::*;

    typedef struct packed {
        logic [63:0] ll;
        logic [63:0] lh;
        logic [63:0] hl;
        logic [63:0] hh;
    } t_part;

    // saturate to 32 bits, flag in the top bit
    function automatic logic [32:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return {1'b1, 32'h7FFF_FFFF};
        end else if (v < -64'sd2147483648) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, v[31:0]};
    endfunction

    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? 32'(~v + 32'd1) : v;
    endfunction

    function automatic t_part partials(input logic [63:0] a, input logic [63:0] b);
        t_part p;
        p.ll = a[31:0]  * b[31:0];
        p.lh = a[31:0]  * b[63:32];
        p.hl = a[63:32] * b[31:0];
        p.hh = a[63:32] * b[63:32];
        return p;
    endfunction

    // control / config
    logic              r_busy;
    logic [WORD_W-1:0] r_time_step;
    logic [WORD_W-1:0] r_kick_gain;
    logic [WORD_W-1:0] r_inv;
    logic              accept;
    logic [10:1]       r_vld;
    logic [3:0]        r_kv;
    logic              r_done;

    // front stages
    t_pkt        r_s1_pkt, r_s2_pkt, r_s3_pkt, r_s4_pkt, r_s5_pkt;
    t_pkt        r_s6_pkt, r_s7_pkt, r_s8_pkt, r_s9_pkt, r_s10_pkt;
    logic [63:0] r_s1_dx, r_s1_dy;
    t_pkt        n_s2_pkt;
    logic [32:0] n_px, n_py;
    logic [31:0] s3_ax, s3_ay;
    logic [63:0] r_s3_sqx, r_s3_sqy;
    logic [63:0] r_s4_r2, r_s5_r2, r_s6_r2, r_s7_r2, r_s8_r2, r_s9_r2, r_s10_r2;
    logic [63:0] r_s5_phi, r_s5_plo;
    logic [64:0] s6_tsum;
    logic        r_s6_big, r_s7_big, r_s8_big, r_s9_big, r_s10_big;
    logic [T_W-1:0] r_s6_t;
    logic [EXP_TABLE_BITS-1:0] s7_idx;
    logic [H_W-1:0] r_s7_h0, r_s7_h1, r_s8_h0, r_s9_h;
    logic [FRAC_BITS-1:0] r_s7_fr;
    logic        s8_dn;
    logic [H_W-1:0] s8_diff;
    logic        r_s8_dn;
    logic [H_W+FRAC_BITS-1:0] r_s8_prod;
    logic [H_W-1:0] s9_corr;
    logic [62:0] s10_prod;
    logic [M_SMALL_W-1:0] r_s10_m;

    // reciprocal unit
    t_div_payload div_in_pl, div_out_pl;
    logic         div_out_v;
    logic [DIV_W-1:0] div_q;

    // kick stages
    t_pkt        r_k0_pkt, r_k1_pkt, r_k2_pkt, r_k3_pkt;
    logic [63:0] r_k0_m, r_k0_kgx, r_k0_kgy;
    t_part       r_k1_px, r_k1_py;
    logic [33:0] r_k2_midx, r_k2_midy;
    logic [65:0] r_k2_hipx, r_k2_hipy;
    logic [65:0] k3_hix, k3_hiy;
    logic        k3_capx, k3_capy;
    logic [32:0] r_k3_kx, r_k3_ky;
    logic        r_k3_capx, r_k3_capy;
    logic [32:0] k4_vx, k4_vy;
    logic signed [63:0] k4_wx, k4_wy;
    logic signed [WORD_W-1:0] r_out_px, r_out_py, r_out_vx, r_out_vy;
    logic        r_out_sat, r_out_last;

    assign accept = start && !busy;
    assign busy   = r_busy;

    // hold busy through reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    // configuration writes; unknown index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= RST_TIME_STEP;
            r_kick_gain <= RST_KICK_GAIN;
            r_inv       <= RST_INV_2SIGSQ;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TIME_STEP:  r_time_step <= i_cfg_wdata;
                CFG_KICK_GAIN:  r_kick_gain <= i_cfg_wdata;
                CFG_INV_2SIGSQ: r_inv       <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_kv   <= '0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[9:1], accept};
            r_kv   <= {r_kv[2:0], div_out_v};
            r_done <= r_kv[3];
        end
    end

    // drift: p + sgn(v) * floor(|v| * dt)
    assign n_px = sat32(r_s1_pkt.vx[31]
        ? 64'({{32{r_s1_pkt.px[31]}}, r_s1_pkt.px} - {16'b0, r_s1_dx[63:16]})
        : 64'({{32{r_s1_pkt.px[31]}}, r_s1_pkt.px} + {16'b0, r_s1_dx[63:16]}));
    assign n_py = sat32(r_s1_pkt.vy[31]
        ? 64'({{32{r_s1_pkt.py[31]}}, r_s1_pkt.py} - {16'b0, r_s1_dy[63:16]})
        : 64'({{32{r_s1_pkt.py[31]}}, r_s1_pkt.py} + {16'b0, r_s1_dy[63:16]}));

    always_comb begin
        n_s2_pkt     = r_s1_pkt;
        n_s2_pkt.px  = n_px[31:0];
        n_s2_pkt.py  = n_py[31:0];
        n_s2_pkt.sat = n_px[32] | n_py[32];
    end

    assign s3_ax = abs32(r_s2_pkt.px);
    assign s3_ay = abs32(r_s2_pkt.py);

    // compare argument against 16.0
    assign s6_tsum = {1'b0, r_s5_phi} + {33'b0, r_s5_plo[63:32]};

    // table lookup and interpolation
    assign s7_idx  = r_s6_t[T_W-1:FRAC_BITS];
    assign s8_dn   = r_s7_h1 <= r_s7_h0;
    assign s8_diff = s8_dn ? (r_s7_h0 - r_s7_h1) : (r_s7_h1 - r_s7_h0);
    assign s9_corr = r_s8_prod[H_W+FRAC_BITS-1:FRAC_BITS];
    assign s10_prod = r_inv * r_s9_h;

    // front pipeline data
    always_ff @(posedge i_clk) begin
        r_s1_pkt  <= '{px: i_pos_x, py: i_pos_y, vx: i_vel_x, vy: i_vel_y,
                       sat: 1'b0, last: i_last_particle};
        r_s1_dx   <= abs32(i_vel_x) * r_time_step;
        r_s1_dy   <= abs32(i_vel_y) * r_time_step;

        r_s2_pkt  <= n_s2_pkt;

        r_s3_pkt  <= r_s2_pkt;
        r_s3_sqx  <= s3_ax * s3_ax;
        r_s3_sqy  <= s3_ay * s3_ay;

        r_s4_pkt  <= r_s3_pkt;
        r_s4_r2   <= r_s3_sqx + r_s3_sqy;

        r_s5_pkt  <= r_s4_pkt;
        r_s5_r2   <= r_s4_r2;
        r_s5_phi  <= r_s4_r2[63:32] * r_inv;
        r_s5_plo  <= r_s4_r2[31:0] * r_inv;

        r_s6_pkt  <= r_s5_pkt;
        r_s6_r2   <= r_s5_r2;
        r_s6_big  <= (r_s5_phi[63:T_W] != '0) || (s6_tsum[64:T_W] != '0);
        r_s6_t    <= s6_tsum[T_W-1:0];

        r_s7_pkt  <= r_s6_pkt;
        r_s7_r2   <= r_s6_r2;
        r_s7_big  <= r_s6_big;
        r_s7_h0   <= H_TAB[{1'b0, s7_idx}];
        r_s7_h1   <= H_TAB[{1'b0, s7_idx} + 1'b1];
        r_s7_fr   <= r_s6_t[FRAC_BITS-1:0];

        r_s8_pkt  <= r_s7_pkt;
        r_s8_r2   <= r_s7_r2;
        r_s8_big  <= r_s7_big;
        r_s8_h0   <= r_s7_h0;
        r_s8_dn   <= s8_dn;
        r_s8_prod <= s8_diff * r_s7_fr;

        r_s9_pkt  <= r_s8_pkt;
        r_s9_r2   <= r_s8_r2;
        r_s9_big  <= r_s8_big;
        r_s9_h    <= r_s8_dn ? (r_s8_h0 - s9_corr) : (r_s8_h0 + s9_corr);

        r_s10_pkt <= r_s9_pkt;
        r_s10_r2  <= r_s9_r2;
        r_s10_big <= r_s9_big;
        r_s10_m   <= s10_prod[61:14];
    end

    assign div_in_pl = '{pkt: r_s10_pkt, big: r_s10_big, m_small: r_s10_m};

    gbpp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_vld[10]),
        .i_divisor  (r_s10_r2),
        .i_payload  (div_in_pl),
        .o_valid    (div_out_v),
        .o_quotient (div_q),
        .o_payload  (div_out_pl)
    );

    // fold partial products and cap the kick at 2^32
    assign k3_hix  = r_k2_hipx + {64'b0, r_k2_midx[33:32]};
    assign k3_hiy  = r_k2_hipy + {64'b0, r_k2_midy[33:32]};
    assign k3_capx = k3_hix[65:16] != '0;
    assign k3_capy = k3_hiy[65:16] != '0;

    // apply the kick against the sign of the coordinate
    assign k4_wx = (r_k3_pkt.px == '0) ? 64'({{32{r_k3_pkt.vx[31]}}, r_k3_pkt.vx})
        : r_k3_pkt.px[31] ? 64'({{32{r_k3_pkt.vx[31]}}, r_k3_pkt.vx} + {31'b0, r_k3_kx})
        : 64'({{32{r_k3_pkt.vx[31]}}, r_k3_pkt.vx} - {31'b0, r_k3_kx});
    assign k4_wy = (r_k3_pkt.py == '0) ? 64'({{32{r_k3_pkt.vy[31]}}, r_k3_pkt.vy})
        : r_k3_pkt.py[31] ? 64'({{32{r_k3_pkt.vy[31]}}, r_k3_pkt.vy} + {31'b0, r_k3_ky})
        : 64'({{32{r_k3_pkt.vy[31]}}, r_k3_pkt.vy} - {31'b0, r_k3_ky});
    assign k4_vx = sat32(k4_wx);
    assign k4_vy = sat32(k4_wy);

    // kick pipeline data
    always_ff @(posedge i_clk) begin
        r_k0_pkt  <= div_out_pl.pkt;
        r_k0_m    <= div_out_pl.big ? div_q : {16'b0, div_out_pl.m_small};
        r_k0_kgx  <= r_kick_gain * abs32(div_out_pl.pkt.px);
        r_k0_kgy  <= r_kick_gain * abs32(div_out_pl.pkt.py);

        r_k1_pkt  <= r_k0_pkt;
        r_k1_px   <= partials(r_k0_kgx, r_k0_m);
        r_k1_py   <= partials(r_k0_kgy, r_k0_m);

        r_k2_pkt  <= r_k1_pkt;
        r_k2_midx <= {2'b0, r_k1_px.ll[63:32]} + {2'b0, r_k1_px.lh[31:0]}
                     + {2'b0, r_k1_px.hl[31:0]};
        r_k2_midy <= {2'b0, r_k1_py.ll[63:32]} + {2'b0, r_k1_py.lh[31:0]}
                     + {2'b0, r_k1_py.hl[31:0]};
        r_k2_hipx <= {2'b0, r_k1_px.hh} + {34'b0, r_k1_px.lh[63:32]}
                     + {34'b0, r_k1_px.hl[63:32]};
        r_k2_hipy <= {2'b0, r_k1_py.hh} + {34'b0, r_k1_py.lh[63:32]}
                     + {34'b0, r_k1_py.hl[63:32]};

        r_k3_pkt  <= r_k2_pkt;
        r_k3_capx <= k3_capx;
        r_k3_capy <= k3_capy;
        r_k3_kx   <= k3_capx ? 33'h1_0000_0000 : {1'b0, k3_hix[15:0], r_k2_midx[31:16]};
        r_k3_ky   <= k3_capy ? 33'h1_0000_0000 : {1'b0, k3_hiy[15:0], r_k2_midy[31:16]};

        r_out_px   <= r_k3_pkt.px;
        r_out_py   <= r_k3_pkt.py;
        r_out_vx   <= k4_vx[31:0];
        r_out_vy   <= k4_vy[31:0];
        r_out_sat  <= r_k3_pkt.sat | k4_vx[32] | k4_vy[32];
        r_out_last <= r_k3_pkt.last;
    end

    assign o_done      = r_done;
    assign o_new_pos_x = r_out_px;
    assign o_new_pos_y = r_out_py;
    assign o_new_vel_x = r_out_vx;
    assign o_new_vel_y = r_out_vy;
    assign o_saturated = r_out_sat;
    assign o_last_out  = r_out_last;

    `ASSERT_NEXT(a_cap_saturates, i_clk, i_rst_n, r_kv[3] && (r_k3_capx || r_k3_capy), r_out_sat)
    `ASSERT_IMPLIES(a_interp_bound, i_clk, i_rst_n, r_vld[9], {33'b0, r_s9_h} <= ONE_Q30)
    `ASSERT_IMPLIES(a_done_follows_div, i_clk, i_rst_n, o_done, $past(div_out_v, 5))

endmodule
